// ----- hdl/sha_pkg.sv -----
`default_nettype none
package sha_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_PAD80, S_PADZ, S_LEN, S_LOAD, S_COMP, S_FIN, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG, SEL_80, SEL_ZERO, SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift;
    byte_sel_t sel;
    logic      load;
    logic      round;
    logic      fin;
    logic      init;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       rnd_last;
  } stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] FILL_END = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd7;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [2047:0] KTAB = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] k_of(input logic [5:0] t);
    k_of = KTAB[2047 - 32 * t -: 32];
  endfunction

  function automatic logic [31:0] iv_of(input logic [2:0] i);
    iv_of = IV[255 - 32 * i -: 32];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sha256_stream_hasher_top.sv -----
// SHA-256 over a byte stream, one optional byte per input item.
// Each full block is loaded, run through 64 rounds and added into the chaining words.
// Throughput: one item per cycle while filling; input stalls during padding, compression
// and digest readout. End of message: padding is shifted in byte by byte, then
// eight digest words, one per accepted output item. Sync active-low reset restores IV.
`default_nettype none
module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] message_byte
  input  wire logic        in_tuser,   // has_byte
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast   // last_word
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // controller: byte intake, padding sequence, compression and digest readout
  sha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .has_byte (in_tuser),
    .eom      (in_tlast),
    .out_acc  (out_acc),
    .stat     (stat),
    .cmd      (cmd),
    .in_rdy   (in_tready),
    .out_vld  (out_tvalid)
  );

  // datapath: 512-bit block/schedule shift line, round unit, chaining words
  sha_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .msg_byte (in_tdata),
    .stat     (stat),
    .digest   (out_tdata)
  );

  assign out_tuser = cmd.out_idx;
  assign out_tlast = (cmd.out_idx == LAST_IDX);

endmodule
`default_nettype wire

// ----- hdl/sha_dp.sv -----
`default_nettype none
module sha_dp
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] msg_byte,
  output stat_t           stat,
  output logic [31:0]     digest
);

  logic [511:0] w_r;          // block bytes, then rolling schedule; word 0 on top
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [5:0]   fill_r;
  logic [5:0]   rnd_r;
  logic [60:0]  len_r;
  logic [63:0]  bits;
  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0]  e, a, ch, maj, bs0, bs1, t1, t2;

  assign bits = {len_r, 3'b000};
  assign w0  = w_r[511 -: 32];
  assign w1  = w_r[479 -: 32];
  assign w9  = w_r[223 -: 32];
  assign w14 = w_r[63 -: 32];

  always_comb begin
    case (cmd.sel)
      SEL_MSG:  byte_in = msg_byte;
      SEL_80:   byte_in = PAD_BYTE;
      SEL_ZERO: byte_in = 8'h00;
      default:  byte_in = bits[63 - 8 * fill_r[2:0] -: 8];
    endcase
  end

  always_comb begin
    s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    w_new = s1 + w9 + s0 + w0;
    a = v_r[0];
    e = v_r[4];
    bs1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    bs0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    ch  = (e & v_r[5]) ^ (~e & v_r[6]);
    maj = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + bs1 + ch + k_of(rnd_r) + w0;
    t2  = bs0 + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= iv_of(3'(i));
    end else begin
      if (cmd.shift) begin
        fill_r <= fill_r + 6'd1;
        if (cmd.sel == SEL_MSG) len_r <= len_r + 61'd1;
      end
      if (cmd.load) rnd_r <= '0;
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fin) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) w_r <= {w_r[503:0], byte_in};
    else if (cmd.round) w_r <= {w_r[479:0], w_new};
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign stat.fill     = fill_r;
  assign stat.rnd_last = (rnd_r == 6'd63);
  assign digest        = h_r[cmd.out_idx];

endmodule
`default_nettype wire

// ----- hdl/sha_ctrl.sv -----
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_acc,
  input  wire logic has_byte,
  input  wire logic eom,
  input  wire logic out_acc,
  input  wire stat_t stat,
  output cmd_t      cmd,
  output logic      in_rdy,
  output logic      out_vld
);

  state_t     state_r, state_nxt, after_r, after_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        if (has_byte && stat.fill == FILL_END) begin
          state_nxt = S_LOAD;
          after_nxt = eom ? S_PAD80 : S_IDLE;
        end else if (eom) begin
          state_nxt = S_PAD80;
        end
      end
      S_PAD80: begin
        state_nxt = S_PADZ;
        if (stat.fill == FILL_END) begin
          state_nxt = S_LOAD;
          after_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (stat.fill == LEN_POS) begin
          state_nxt = S_LEN;
        end else if (stat.fill == FILL_END) begin
          state_nxt = S_LOAD;
          after_nxt = S_PADZ;
        end
      end
      S_LEN: if (stat.fill == FILL_END) begin
        state_nxt = S_LOAD;
        after_nxt = S_OUT;
      end
      S_LOAD: state_nxt = S_COMP;
      S_COMP: if (stat.rnd_last) state_nxt = S_FIN;
      S_FIN:  state_nxt = after_r;
      S_OUT: if (out_acc) begin
        idx_nxt = idx_r + 3'd1;
        if (idx_r == LAST_IDX) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.sel     = SEL_MSG;
    cmd.out_idx = idx_r;
    in_rdy      = 1'b0;
    out_vld     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy    = 1'b1;
        cmd.shift = in_acc && has_byte;
      end
      S_PAD80: begin
        cmd.shift = 1'b1;
        cmd.sel   = SEL_80;
      end
      S_PADZ: begin
        cmd.shift = (stat.fill != LEN_POS);
        cmd.sel   = SEL_ZERO;
      end
      S_LEN: begin
        cmd.shift = 1'b1;
        cmd.sel   = SEL_LEN;
      end
      S_LOAD: cmd.load  = 1'b1;
      S_COMP: cmd.round = 1'b1;
      S_FIN:  cmd.fin   = 1'b1;
      S_OUT: begin
        out_vld  = 1'b1;
        cmd.init = out_acc && (idx_r == LAST_IDX);
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_comp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |=> state_r == S_COMP) else $error("load not followed by rounds");
  a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> state_r != S_FIN) else $error("finalize repeated");
  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEN |-> stat.fill >= LEN_POS) else $error("length bytes misplaced");
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> idx_r == 3'd0) else $error("digest index not cleared");
`endif

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import sha_pkg::*;

  // Digest word as it leaves the hasher: word, its position, last flag.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  // Round constants and initial hash values, written out here so the
  // predictor does not lean on the package helpers.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Scoreboard: a software SHA-256 that tracks the stream byte by byte
  // and queues the eight digest words at each end of message.
  class digest_scoreboard;
    logic [31:0]  hash_h [8];
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [60:0]  msg_len;
    digest_item_t pending_digest [$];
    int unsigned  mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hash_h[i] = START_H[i];
      fill = 0;
      msg_len = '0;
    endfunction

    function automatic logic [31:0] rotr(logic [31:0] x, int s);
      return (x >> s) | (x << (32 - s));
    endfunction

    function void compress();
      logic [31:0] v [8];
      logic [31:0] w [64];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_h[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endfunction

    // Accepted input item.
    function void note_input(logic [7:0] b, logic has_b, logic eom);
      logic [63:0] bits;
      digest_item_t d;
      if (has_b) begin
        blk[fill] = b;
        fill++;
        msg_len++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      blk[fill] = PAD_BYTE;
      fill++;
      if (fill > 56) begin
        while (fill < 64) blk[fill++] = 8'h00;
        compress();
        fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      bits = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = hash_h[i];
        d.idx  = 3'(i);
        d.last = (i == 7);
        pending_digest.push_back(d);
      end
      restart();
    endfunction

    // Accepted output item.
    function void check_output(logic [31:0] word, logic [2:0] idx, logic last);
      digest_item_t e;
      if (pending_digest.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest item: word %h idx %0d last %0b", word, idx, last);
        return;
      end
      e = pending_digest.pop_front();
      if (word !== e.word || idx !== e.idx || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                   e.word, e.idx, e.last, word, idx, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] message_byte
  logic        in_tuser = 1'b0; // has_byte
  logic        in_tlast = 1'b0; // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] digest_word
  logic [2:0]  out_tuser;       // [2:0] word_index
  logic        out_tlast;       // last_word

  digest_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_phase = 0;
  bit          rx_throttle = 1'b1;

  localparam int unsigned CYCLE_LIMIT = 400000;

  always #4 clk = ~clk;

  sha256_stream_hasher_top dut (.*);

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: stalls on a rotating pattern, sometimes ready for long runs.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_output(out_tdata, out_tuser, out_tlast);
    stall_phase <= stall_phase + 1;
    if (stall_phase % 200 == 0) rx_throttle <= $urandom_range(0, 2) != 0;
    if (!rx_throttle) out_tready <= 1'b1;
    else out_tready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
  end

  // Send one item; holds valid until accepted. Gaps come between bursts.
  task automatic send_item(logic [7:0] b, logic has_b, logic eom);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has_b;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b, has_b, eom);
  endtask

  // Whole message of n random bytes, with occasional empty items mixed in.
  task automatic send_message(int unsigned n, bit eom_alone);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == n - 1) && !eom_alone);
    end
    if (eom_alone || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned n_items;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, extremes, empty items, "abc".
    send_item(8'hff, 1'b0, 1'b1);            // empty message, byte ignored
    send_item(8'h00, 1'b0, 1'b0);            // empty item
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);            // two-byte message, extremes
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);              // standard "abc" vector
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);            // end carried without a byte

    // Random: mostly short messages; a few that cross the 55/56/64 byte
    // padding edges, some of which need two final blocks.
    n_items = 0;
    while (n_items < 130) begin
      int unsigned len;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 57);
        1: len = $urandom_range(62, 65);
        default: len = $urandom_range(0, 12);
      endcase
      send_message(len, $urandom_range(0, 3) == 0);
      n_items += len + 1;
    end
    in_tvalid <= 1'b0;

    while (sb.pending_digest.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_digest.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sha256_stream_hasher_top.f -----
hdl/sha_pkg.sv
hdl/sha_dp.sv
hdl/sha_ctrl.sv
hdl/sha256_stream_hasher_top.sv
dv/testbench.sv
